[hdl/bgvs_pkg.sv]
// Shared types and constants of the grown vector store.
package bgvs_pkg;

    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int STATUS_W    = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGINAL_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE    = 1'b1;

    localparam logic [CFG_W-1:0] ORIGINAL_SIZE_RESET = 11'd16;
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET    = 11'd16;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_GET  = 2'd2,
        OP_SET  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_OVERFLOW    = 3'd1,
        ST_UNDERFLOW   = 3'd2,
        ST_WRONG_INDEX = 3'd3,
        ST_NO_ROOM     = 3'd4
    } status_t;

    typedef struct packed {
        logic    mem_we;
        logic    mem_re;
        status_t status;
    } bgvs_req_t;

endpackage

[hdl/block_grown_vector_store_top.sv]
// Top level of the grown vector store: request pipeline, result register and assertions.
//
// Requests arrive on the req channel (operation, index, write_value) and each one
// gives exactly one result on the rsp channel (status, read_value, item_count,
// capacity). A transaction takes place on a rising edge where valid is high and
// stall is low. The count and capacity are decided in the cycle the request is
// taken; the word store is a single-port memory with a registered read, so the
// request waits in the memory stage register while the word is read, then moves
// into the result register, from which the result transaction takes place.
// One request per cycle is sustained unless the receiver stalls: one memory access
// per request, and a request may use the count left by the one just before it.
// When the receiver stalls, the result register holds its transaction, the request
// in the memory stage waits behind it, and req_stall rises once both are occupied.
// The two registers cfg index 0 (original size) and 1 (block size) are written over
// the cfg channel, which is always ready; each write reloads the capacity with the
// original size and keeps the count and the stored words.
// Reset clears the count, sets both registers and the capacity to 16 and empties
// the pipeline; the stored words are undefined until written.
module block_grown_vector_store_top
    import bgvs_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [1:0]                operation,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [VALUE_W-1:0] write_value,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [STATUS_W-1:0]       status,
    output logic signed [VALUE_W-1:0] read_value,
    output logic [CFG_W-1:0]          item_count,
    output logic [CFG_W-1:0]          capacity,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 2048) + 1;

    bgvs_req_t          req;
    logic [AW-1:0]      mem_addr;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      cap_next;
    logic [VALUE_W-1:0] mem_rdata;

    logic               accept;
    logic               out_free;
    logic               s1_adv;
    logic               cfg_we;

    logic               s1_valid_reg;
    status_t            s1_status_reg;
    logic               s1_re_reg;
    logic [CW-1:0]      s1_count_reg;
    logic [CW-1:0]      s1_cap_reg;

    logic               rsp_valid_reg;
    status_t            rsp_status_reg;
    logic [VALUE_W-1:0] rsp_value_reg;
    logic [CFG_W-1:0]   rsp_count_reg;
    logic [CFG_W-1:0]   rsp_cap_reg;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    bgvs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .index      (index),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .addr       (mem_addr),
        .count_next (count_next),
        .cap_next   (cap_next)
    );

    bgvs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (accept && req.mem_we),
        .re    (accept && req.mem_re),
        .addr  (mem_addr),
        .wdata (write_value),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= req.status;
            s1_re_reg     <= req.mem_re;
            s1_count_reg  <= count_next;
            s1_cap_reg    <= cap_next;
        end
        if (s1_adv)
        begin
            rsp_status_reg <= s1_status_reg;
            rsp_value_reg  <= s1_re_reg ? mem_rdata : '0;
            rsp_count_reg  <= s1_count_reg[CFG_W-1:0];
            rsp_cap_reg    <= s1_cap_reg[CFG_W-1:0];
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_status_reg;
    assign read_value = rsp_value_reg;
    assign item_count = rsp_count_reg;
    assign capacity   = rsp_cap_reg;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("An accepted request did not reach the memory stage.");

    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> read_value == '0)
        else $error("A failed request returned a non-zero word.");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_UNDERFLOW |-> item_count == '0)
        else $error("An underflow was reported with items still stored.");

    a_read_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_re_reg |-> s1_status_reg == ST_OK)
        else $error("A memory read was issued for a failed request.");

endmodule

[hdl/bgvs_mem.sv]
// Single-port word store with a registered read port.
module bgvs_mem
    import bgvs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic               clk,
    input  logic               we,
    input  logic               re,
    input  logic [AW-1:0]      addr,
    input  logic [VALUE_W-1:0] wdata,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] store_reg [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/bgvs_ctrl.sv]
// Count, capacity and configuration registers with the per-request decision logic.
module bgvs_ctrl
    import bgvs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CW    = 13
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             operation,
    input  logic [INDEX_W-1:0]     index,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output bgvs_req_t              req,
    output logic [AW-1:0]          addr,
    output logic [CW-1:0]          count_next,
    output logic [CW-1:0]          cap_next
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    cap_reg;
    logic [CFG_W-1:0] orig_reg;
    logic [CFG_W-1:0] block_reg;
    logic [CFG_W-1:0] orig_next;
    logic [CFG_W-1:0] block_next;

    logic [CW-1:0] block_ext;
    logic [CW-1:0] orig_ext;
    logic [CW-1:0] dbl_block;
    logic [CW-1:0] grown;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] index_ext;
    logic [CW-1:0] new_cap;
    logic [CW-1:0] addr_full;

    assign block_ext = CW'(block_reg);
    assign orig_ext  = CW'(orig_reg);
    assign dbl_block = CW'({block_reg, 1'b0});
    assign grown     = cap_reg + block_ext;
    assign count_m1  = count_reg - CW'(1);
    assign index_ext = CW'(index);

    always_comb
    begin
        req        = '{mem_we: 1'b0, mem_re: 1'b0, status: ST_OK};
        addr_full  = '0;
        count_next = count_reg;
        cap_next   = cap_reg;
        new_cap    = cap_reg;
        case (op_t'(operation))
            OP_PUSH:
            begin
                if (count_reg >= cap_reg)
                begin
                    if (block_reg == '0)
                    begin
                        req.status = ST_OVERFLOW;
                    end
                    else if (grown > DEPTH_C)
                    begin
                        req.status = ST_NO_ROOM;
                    end
                    else
                    begin
                        new_cap = grown;
                    end
                end
                if (req.status == ST_OK && count_reg >= DEPTH_C)
                begin
                    req.status = ST_NO_ROOM;
                end
                if (req.status == ST_OK)
                begin
                    req.mem_we = 1'b1;
                    addr_full  = count_reg;
                    count_next = count_reg + CW'(1);
                    cap_next   = new_cap;
                end
            end
            OP_POP:
            begin
                if (count_reg == '0 || count_reg > DEPTH_C)
                begin
                    req.status = ST_UNDERFLOW;
                end
                else
                begin
                    req.mem_re = 1'b1;
                    addr_full  = count_m1;
                    count_next = count_m1;
                    if (block_reg != '0 && cap_reg > orig_ext && cap_reg >= count_m1 &&
                        (cap_reg - count_m1) >= dbl_block)
                    begin
                        cap_next = cap_reg - block_ext;
                    end
                end
            end
            OP_GET, OP_SET:
            begin
                if (index_ext >= count_reg || index_ext >= DEPTH_C)
                begin
                    req.status = ST_WRONG_INDEX;
                end
                else
                begin
                    addr_full = index_ext;
                    if (op_t'(operation) == OP_GET)
                    begin
                        req.mem_re = 1'b1;
                    end
                    else
                    begin
                        req.mem_we = 1'b1;
                    end
                end
            end
            default:
            begin
                req.status = ST_OK;
            end
        endcase
    end

    assign addr = addr_full[AW-1:0];

    always_comb
    begin
        orig_next  = orig_reg;
        block_next = block_reg;
        case (cfg_index)
            REG_ORIGINAL_SIZE: orig_next  = cfg_data;
            REG_BLOCK_SIZE:    block_next = cfg_data;
            default:           orig_next  = orig_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CW'(ORIGINAL_SIZE_RESET);
            orig_reg  <= ORIGINAL_SIZE_RESET;
            block_reg <= BLOCK_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            orig_reg  <= orig_next;
            block_reg <= block_next;
            cap_reg   <= CW'(orig_next);
        end
        else if (accept)
        begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the grown vector store: push, pop, get and set against a mirror.
module testbench;
    import bgvs_pkg::*;

    localparam int DEPTH = 1024;
    localparam int SHRINK_FACTOR = 2;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        status_t            status;
        logic [VALUE_W-1:0] read_value;
        logic [CFG_W-1:0]   item_count;
        logic [CFG_W-1:0]   capacity;
    } vector_result_t;

    class vector_store_mirror;
        logic [VALUE_W-1:0] words [DEPTH];
        logic [CFG_W-1:0]   stored;
        logic [CFG_W-1:0]   logical_cap;
        logic [CFG_W-1:0]   orig_size;
        logic [CFG_W-1:0]   step_size;
        vector_result_t     pending_results [$];
        int                 mismatches;

        function new();
            stored      = '0;
            orig_size   = ORIGINAL_SIZE_RESET;
            step_size   = BLOCK_SIZE_RESET;
            logical_cap = ORIGINAL_SIZE_RESET;
            mismatches  = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] reg_index, logic [CFG_W-1:0] value);
            case (reg_index)
                REG_ORIGINAL_SIZE: orig_size = value;
                REG_BLOCK_SIZE:    step_size = value;
                default:           ;
            endcase
            logical_cap = orig_size;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void apply_request(op_t op, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] word);
            vector_result_t     want;
            logic [CFG_W-1:0]   grown;
            logic [VALUE_W-1:0] value;
            status_t            st;
            st    = ST_OK;
            value = '0;
            grown = logical_cap;
            case (op)
                OP_PUSH:
                begin
                    if (stored >= logical_cap)
                    begin
                        if (step_size == 0)
                            st = ST_OVERFLOW;
                        else if (int'(logical_cap) + int'(step_size) > DEPTH)
                            st = ST_NO_ROOM;
                        else
                            grown = logical_cap + step_size;
                    end
                    if (st == ST_OK && int'(stored) >= DEPTH)
                        st = ST_NO_ROOM;
                    if (st == ST_OK)
                    begin
                        logical_cap = grown;
                        words[stored[INDEX_W-1:0]] = word;
                        stored++;
                    end
                end
                OP_POP:
                begin
                    if (stored == 0)
                        st = ST_UNDERFLOW;
                    else
                    begin
                        value = words[INDEX_W'(stored - 1'b1)];
                        stored--;
                        if (step_size != 0 && logical_cap > orig_size && logical_cap >= stored
                            && int'(logical_cap - stored) >= SHRINK_FACTOR * int'(step_size))
                            logical_cap -= step_size;
                    end
                end
                default:
                begin
                    if (idx >= stored)
                        st = ST_WRONG_INDEX;
                    else if (op == OP_GET)
                        value = words[idx];
                    else
                        words[idx] = word;
                end
            endcase
            want.status     = st;
            want.read_value = value;
            want.item_count = stored;
            want.capacity   = logical_cap;
            pending_results.push_back(want);
        endfunction

        function void compare_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] value,
                                     logic [CFG_W-1:0] total, logic [CFG_W-1:0] cap);
            vector_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("Result transaction arrived with no request outstanding.");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, st);
                mismatches++;
            end
            if (value !== want.read_value)
            begin
                $error("read_value: expected %0d, actual %0d",
                       $signed(want.read_value), $signed(value));
                mismatches++;
            end
            if (total !== want.item_count)
            begin
                $error("item_count: expected %0d, actual %0d", want.item_count, total);
                mismatches++;
            end
            if (cap !== want.capacity)
            begin
                $error("capacity: expected %0d, actual %0d", want.capacity, cap);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [1:0]                operation = OP_PUSH;
    logic [INDEX_W-1:0]        index = '0;
    logic signed [VALUE_W-1:0] write_value = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [CFG_W-1:0]          item_count;
    logic [CFG_W-1:0]          capacity;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = REG_ORIGINAL_SIZE;
    logic [CFG_W-1:0]          cfg_data = '0;

    vector_store_mirror mirror;
    int burst_left = 0;
    int hold_mode = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    block_grown_vector_store_top #(.DEPTH(DEPTH)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .index       (index),
        .write_value (write_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .read_value  (read_value),
        .item_count  (item_count),
        .capacity    (capacity),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (hold_left == 0)
        begin
            hold_left = $urandom_range(200, 20);
            hold_mode = $urandom_range(2, 0);
        end
        hold_left--;
        case (hold_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(1, 0) == 1);
            default: rsp_stall <= ($urandom_range(3, 0) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            mirror.compare_result(status, read_value, item_count, capacity);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL block_grown_vector_store_top");
                $finish;
            end
        end
    end

    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(9, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if (mirror.stored != 0 && $urandom_range(9, 0) < 8)
            return INDEX_W'($urandom_range(int'(mirror.stored) - 1, 0));
        else if ($urandom_range(1, 0) == 0)
            return INDEX_W'(mirror.stored);
        return INDEX_W'($urandom_range(DEPTH - 1, 0));
    endfunction

    task automatic send_request(input op_t op, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                      : $urandom_range(40, 1);
        end
        req_valid   <= 1'b1;
        operation   <= op;
        index       <= idx;
        write_value <= word;
        do @(posedge clk); while (req_stall);
        mirror.apply_request(op, idx, word);
        burst_left--;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (mirror.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] orig, input logic [CFG_W-1:0] step);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ORIGINAL_SIZE;
        cfg_data  <= orig;
        do @(posedge clk); while (!cfg_ready);
        mirror.write_register(REG_ORIGINAL_SIZE, orig);
        cfg_index <= REG_BLOCK_SIZE;
        cfg_data  <= step;
        do @(posedge clk); while (!cfg_ready);
        mirror.write_register(REG_BLOCK_SIZE, step);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(input int n);
        int  push_weight;
        int  roll;
        op_t op;
        for (int k = 0; k < n; k++)
        begin
            push_weight = (k < n / 2) ? 55 : 20;
            roll = $urandom_range(99, 0);
            if (roll < push_weight)
                op = OP_PUSH;
            else if (roll < push_weight + 30)
                op = OP_POP;
            else if (roll[0])
                op = OP_GET;
            else
                op = OP_SET;
            send_request(op, pick_index(), pick_word());
        end
    endtask

    task automatic directed_requests();
        send_request(OP_POP, '0, '0);
        send_request(OP_GET, '0, '0);
        send_request(OP_SET, '1, 32'h7fff_ffff);
        send_request(OP_PUSH, '1, 32'h8000_0000);
        send_request(OP_PUSH, '0, 32'h7fff_ffff);
        send_request(OP_PUSH, '0, '0);
        send_request(OP_PUSH, '0, '1);
        send_request(OP_GET, 10'd0, '0);
        send_request(OP_GET, 10'd3, '0);
        send_request(OP_GET, 10'd4, '0);
        send_request(OP_SET, 10'd1, 32'h5555_5555);
        send_request(OP_GET, 10'd1, '0);
        send_request(OP_POP, '0, '0);
        while (mirror.stored < 17)
            send_request(OP_PUSH, INDEX_W'($urandom_range(DEPTH - 1, 0)), pick_word());
    endtask

    task automatic fill_to_physical_end();
        configure(CFG_W'(DEPTH), 16);
        while (int'(mirror.stored) < DEPTH)
            send_request(OP_PUSH, INDEX_W'($urandom_range(DEPTH - 1, 0)), pick_word());
        send_request(OP_PUSH, '0, pick_word());
        drain();
        configure(8, 8);
        send_request(OP_PUSH, '1, pick_word());
        send_request(OP_GET, INDEX_W'(DEPTH - 1), '0);
        send_request(OP_POP, '0, '0);
        random_requests(60);
    endtask

    initial
    begin
        mirror = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_requests();
        drain();
        configure(4, 2);
        random_requests(150);
        drain();
        configure(0, 0);
        random_requests(50);
        drain();
        configure(1023, 1);
        random_requests(50);
        drain();
        configure(0, CFG_W'(DEPTH));
        random_requests(50);
        drain();
        configure(CFG_W'($urandom_range(DEPTH, 0)), CFG_W'($urandom_range(64, 0)));
        random_requests(60);
        drain();
        configure(2, 1);
        random_requests(100);
        drain();
        fill_to_physical_end();
        drain();
        repeat (8) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("PASS block_grown_vector_store_top");
        else
            $display("FAIL block_grown_vector_store_top");
        $finish;
    end

endmodule

[filelist.f]
hdl/bgvs_pkg.sv
hdl/bgvs_mem.sv
hdl/bgvs_ctrl.sv
hdl/block_grown_vector_store_top.sv
tb/sv/testbench.sv
